/* rtl/mlf_pkg.sv */
// Shared types and constants for the MAC learning forwarder.
`timescale 1ns / 1ps
package mlf_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int MAX_PORTS_DEF   = 16;
   localparam int MAX_RESULTS     = 15;
   localparam int MAC_W           = 48;
   localparam int PORT_W          = 4;
   localparam int PORT_CNT_W      = 5;
   localparam logic [PORT_CNT_W-1:0] PORT_CNT_RESET = 5'd1;

   typedef struct packed {
      logic [MAC_W-1:0]  src_mac;
      logic [MAC_W-1:0]  dst_mac;
      logic [PORT_W-1:0] in_port;
   } req_type;

   typedef struct packed {
      logic [PORT_W-1:0] out_port;
      logic              flooded;
      logic              dropped;
      logic              learn_failed;
      logic              last;
   } rsp_type;

   // Lookup token handed from cell to cell along the table.
   typedef struct packed {
      logic              valid;
      logic [MAC_W-1:0]  src_mac;
      logic [MAC_W-1:0]  dst_mac;
      logic [PORT_W-1:0] in_port;
      logic              src_found;
      logic              dst_found;
      logic [PORT_W-1:0] dst_port;
   } token_type;

endpackage

/* rtl/mlf_cell.sv */
// One table cell: holds one learned MAC/port pair and passes the lookup token on.
`timescale 1ns / 1ps
module mlf_cell
   import mlf_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int INDEX       = 0,
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [CNT_W-1:0] entry_count,
   input  token_type        prev_tok,
   output token_type        next_tok,
   output logic             learn
);

   logic [MAC_W-1:0]  mac_ff;
   logic [PORT_W-1:0] port_ff;
   token_type         tok_ff;
   token_type         tok_in;
   logic              used;
   logic              hit_src;
   logic              hit_dst;

   assign used    = CNT_W'(INDEX) < entry_count;
   assign hit_src = used && (mac_ff == prev_tok.src_mac);
   assign hit_dst = used && (mac_ff == prev_tok.dst_mac);
   // entries fill from the front, so the first unused cell is the append slot
   assign learn   = advance && prev_tok.valid && !used && !prev_tok.src_found;

   always_comb begin
      tok_in           = prev_tok;
      tok_in.src_found = prev_tok.src_found || hit_src || learn;
      if (!prev_tok.dst_found) begin
         if (hit_dst) begin
            tok_in.dst_found = 1'b1;
            tok_in.dst_port  = port_ff;
         end else if (learn && (prev_tok.dst_mac == prev_tok.src_mac)) begin
            tok_in.dst_found = 1'b1;
            tok_in.dst_port  = prev_tok.in_port;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (learn) begin
         mac_ff  <= prev_tok.src_mac;
         port_ff <= prev_tok.in_port;
      end
   end

   assign next_tok = tok_ff;

endmodule

/* rtl/mlf_emitter.sv */
// Result sequencer: turns a finished lookup into one, a flood of, or a drop result.
`timescale 1ns / 1ps
module mlf_emitter
   import mlf_pkg::*;
#(
   parameter int MAX_PORTS = MAX_PORTS_DEF,
   localparam int QW       = $clog2(MAX_PORTS + 4),
   localparam int CW       = $clog2(MAX_RESULTS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  token_type     tail,
   input  logic [QW-1:0] ports,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   output logic          load_ok
);

   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   logic [QW-1:0]     cur_ff;
   logic [CW-1:0]     cnt_ff;
   logic [PORT_W-1:0] arr_ff;

   logic              accept;
   logic              load;
   logic              step;
   logic [QW-1:0]     first_p;
   logic [QW-1:0]     first_n;
   logic [QW-1:0]     step_p;
   logic [QW-1:0]     step_n;

   // next flood port after p, skipping the arrival port
   function automatic logic [QW-1:0] nxt(input logic [QW-1:0] p, input logic [PORT_W-1:0] a);
      logic [QW-1:0] q;
      q = p + 1'b1;
      if (int'(q) == int'(a)) q = q + 1'b1;
      return q;
   endfunction

   assign accept  = rsp_valid_ff && !rsp_stall;
   assign load_ok = !rsp_valid_ff || (accept && rsp_ff.last);
   assign load    = tail.valid && load_ok;
   assign step    = accept && !rsp_ff.last;

   assign first_p = (tail.in_port == '0) ? QW'(1) : '0;
   assign first_n = nxt(first_p, tail.in_port);
   assign step_p  = nxt(cur_ff, arr_ff);
   assign step_n  = nxt(step_p, arr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         priority if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (accept && rsp_ff.last) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (load) begin
         arr_ff              <= tail.in_port;
         cur_ff              <= first_p;
         cnt_ff              <= '0;
         rsp_ff.learn_failed <= !tail.src_found;
         priority if (tail.dst_found) begin
            rsp_ff.out_port <= tail.dst_port;
            rsp_ff.flooded  <= 1'b0;
            rsp_ff.dropped  <= 1'b0;
            rsp_ff.last     <= 1'b1;
         end else if (first_p < ports) begin
            rsp_ff.out_port <= PORT_W'(first_p);
            rsp_ff.flooded  <= 1'b1;
            rsp_ff.dropped  <= 1'b0;
            rsp_ff.last     <= !((first_n < ports) && (1 < MAX_RESULTS));
         end else begin
            rsp_ff.out_port <= '0;
            rsp_ff.flooded  <= 1'b0;
            rsp_ff.dropped  <= 1'b1;
            rsp_ff.last     <= 1'b1;
         end
      end else if (step) begin
         cur_ff          <= step_p;
         cnt_ff          <= cnt_ff + 1'b1;
         rsp_ff.out_port <= PORT_W'(step_p);
         rsp_ff.last     <= !((step_n < ports) && ((int'(cnt_ff) + 2) < MAX_RESULTS));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_not_both : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.flooded && rsp_ff.dropped))
      else $error("result both flooded and dropped");

   a_single_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.flooded |-> rsp_ff.last)
      else $error("unicast or drop result not marked last");

   a_flood_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.flooded |-> (cur_ff < ports) && (int'(cnt_ff) < MAX_RESULTS))
      else $error("flood result outside port range or result limit");

   a_step_flood : assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff && rsp_ff.flooded)
      else $error("flood step did not yield a flood result");

endmodule

/* rtl/mac_learning_forwarder_top.sv */
// Top level of the MAC learning forwarder: config register, cell chain, result sequencer.
//
//   channel   direction   handshake                 payload
//   req       in          req_valid / req_stall     req_data (req_type)
//   rsp       out         rsp_valid / rsp_stall     rsp_data (rsp_type)
//   csr       in          csr_wr_en                 csr_wr_data (port count)
//
// A request walks the chain of TABLE_DEPTH cells, one cell a cycle unless held; its first
// result is registered in the sequencer after it leaves the last cell. Requests enter back
// to back while the sequencer keeps up; the sequencer issues one result a cycle while
// rsp_stall is low, so a frame yields 1 to MAX_RESULTS results (1 for a unicast or drop).
// Reset clears the entry count; no clearing pass runs.
// A stall on rsp freezes the whole chain once its tail token waits; req_stall then rises.
`timescale 1ns / 1ps
module mac_learning_forwarder_top
   import mlf_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int MAX_PORTS   = MAX_PORTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [PORT_CNT_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int QW    = $clog2(MAX_PORTS + 4);

   logic [PORT_CNT_W-1:0] port_cnt_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      cnt_in;
   logic [QW-1:0]         ports;
   logic                  advance;
   logic                  load_ok;
   logic [TABLE_DEPTH-1:0] learn;
   token_type             chain [TABLE_DEPTH+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         port_cnt_ff <= PORT_CNT_RESET;
      end else if (csr_wr_en) begin
         port_cnt_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (int'(port_cnt_ff) > MAX_PORTS) ports = QW'(MAX_PORTS);
      else ports = QW'(port_cnt_ff);
   end

   assign advance   = !chain[TABLE_DEPTH].valid || load_ok;
   assign req_stall = !advance;

   // fresh token: nothing found yet
   assign chain[0] = {req_valid, req_data.src_mac, req_data.dst_mac, req_data.in_port,
                      1'b0, 1'b0, PORT_W'(0)};

   // at most one cell appends per cycle: the one at the current count
   assign cnt_in = cnt_ff + CNT_W'(|learn);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      mlf_cell #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .INDEX       (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .entry_count (cnt_ff),
         .prev_tok    (chain[i]),
         .next_tok    (chain[i+1]),
         .learn       (learn[i])
      );
   end

   mlf_emitter #(
      .MAX_PORTS (MAX_PORTS)
   ) u_emitter (
      .clock     (clock),
      .reset     (reset),
      .tail      (chain[TABLE_DEPTH]),
      .ports     (ports),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .load_ok   (load_ok)
   );

   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) <= TABLE_DEPTH)
      else $error("entry count beyond table depth");

   a_cnt_step : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (cnt_ff == $past(cnt_ff) || cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("entry count moved by more than one");

   a_lf_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.learn_failed |-> int'(cnt_ff) == TABLE_DEPTH)
      else $error("learn failure reported with table not full");

endmodule
